@@ sv/replacement_selection_runs_defines.svh @@
// Assertion helpers shared by the block's checks.
`ifndef REPLACEMENT_SELECTION_RUNS_DEFINES_SVH
`define REPLACEMENT_SELECTION_RUNS_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RSR_ASSERT_NOW(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define RSR_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/rsr_pkg.sv @@
`default_nettype none

package rsr_pkg;

    localparam int KEY_W = 32;
    localparam int RUN_W = 16;
    localparam int CFG_W = 5;

    localparam logic [CFG_W-1:0] BUF_SIZE_RESET = 5'd16;

    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_FLUSH  = 1'b1;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [RUN_W-1:0]        run_t;
    typedef logic [CFG_W-1:0]        cfg_t;

endpackage

`default_nettype wire

@@ sv/replacement_selection_runs.sv @@
`default_nettype none
// Replacement-selection run generator for an external sort. Issue a transaction with
// start while busy is low: req_type 0 carries a record (record_key, record_payload),
// req_type 1 flushes the buffer. While fewer than buffer_size slots hold records, a
// record is stored, busy stays low and nothing is emitted. Once the buffer is full,
// busy is high after a record is accepted while the slot RAM is scanned one slot per
// cycle through its single read port to find the smallest unfrozen key (lowest slot
// on ties), then the emit state emits it and writes the new record back into its
// slot. The result strobes in the first cycle with busy low, and only from that cycle
// on can the next record be accepted. A flush drains the buffer, first the unfrozen
// records and then the frozen ones, each in key order, with a scan of the slots before
// each emitted record. Each result appears for exactly one cycle with result_valid
// high; the receiver cannot stall, so capture it on that cycle. run_last marks the
// record that closes a run, flush_last the final record of a flush. The user must
// write buffer_size through cfg_we/cfg_wdata only while the block is idle; the block
// does not enforce it. 0 acts as 1 and values above MAX_SLOTS act as MAX_SLOTS. No
// clearing pass is needed after reset: only slots below the fill count are ever read.

`include "replacement_selection_runs_defines.svh"

module replacement_selection_runs
    import rsr_pkg::*;
#(
    parameter int MAX_SLOTS    = 16,
    parameter int PAYLOAD_BITS = 64
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic                    req_type,
    input  wire logic signed [KEY_W-1:0] record_key,
    input  wire logic [PAYLOAD_BITS-1:0] record_payload,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_W-1:0]        cfg_wdata,
    output logic                         result_valid,
    output logic signed [KEY_W-1:0]      out_key,
    output logic [PAYLOAD_BITS-1:0]      out_payload,
    output logic [RUN_W-1:0]             run_number,
    output logic                         run_last,
    output logic                         flush_last
);

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int REC_W = KEY_W + PAYLOAD_BITS;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} state_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        fill_count_reg;
    logic [MAX_SLOTS-1:0]    frozen_reg;
    logic [MAX_SLOTS-1:0]    taken_reg;
    run_t                    cur_run_reg;
    cfg_t                    buf_size_reg;
    logic                    flush_mode_reg;
    logic                    phase_reg;
    logic [CNT_W-1:0]        rd_ptr_reg;
    logic                    pipe_valid_reg;
    logic [IDX_W-1:0]        pipe_idx_reg;
    logic                    best_found_reg;
    logic [IDX_W-1:0]        best_idx_reg;
    key_t                    best_key_reg;
    logic [PAYLOAD_BITS-1:0] best_pay_reg;
    key_t                    new_key_reg;
    logic [PAYLOAD_BITS-1:0] new_pay_reg;
    logic                    result_valid_reg;
    key_t                    out_key_reg;
    logic [PAYLOAD_BITS-1:0] out_pay_reg;
    run_t                    run_number_reg;
    logic                    run_last_reg;
    logic                    flush_last_reg;

    // Slot RAM: key in the upper bits, payload below.
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [REC_W-1:0]        ram_wdata;
    logic                    ram_re;
    logic [REC_W-1:0]        ram_rdata;
    key_t                    rd_key;
    logic [PAYLOAD_BITS-1:0] rd_pay;

    logic                    accept;
    logic [CMP_W-1:0]        size_ext;
    logic [CMP_W-1:0]        eff_size;
    logic                    fill_room;
    logic [MAX_SLOTS-1:0]    valid_mask;
    logic [MAX_SLOTS-1:0]    open_mask;
    logic [MAX_SLOTS-1:0]    frozen_mask;
    logic [MAX_SLOTS-1:0]    elig_mask;
    logic [MAX_SLOTS-1:0]    best_onehot;
    logic [MAX_SLOTS-1:0]    frozen_upd;
    logic                    take;
    logic                    new_below;
    logic                    any_open_after;
    logic                    remaining;
    logic                    more_frozen;
    logic                    emit_run_last;
    logic                    emit_flush_last;
    logic                    scan_done;

    rsr_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_ptr_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_key = ram_rdata[REC_W-1 -: KEY_W];
    assign rd_pay = ram_rdata[PAYLOAD_BITS-1:0];

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && (state_reg == S_IDLE);

    // Clamp the configured size into 1..MAX_SLOTS.
    always_comb
    begin
        size_ext = CMP_W'(buf_size_reg);
        if (size_ext == '0)
        begin
            eff_size = CMP_W'(1);
        end
        else if (size_ext > CMP_W'(MAX_SLOTS))
        begin
            eff_size = CMP_W'(MAX_SLOTS);
        end
        else
        begin
            eff_size = size_ext;
        end
    end

    assign fill_room = (CMP_W'(fill_count_reg) < eff_size);

    // Slots below the fill count are the ones in use.
    always_comb
    begin
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            valid_mask[i] = (CNT_W'(i) < fill_count_reg);
        end
    end

    assign open_mask   = valid_mask & ~frozen_reg;
    assign frozen_mask = valid_mask & frozen_reg;
    assign elig_mask   = flush_mode_reg
                       ? (valid_mask & ~taken_reg & (phase_reg ? frozen_reg : ~frozen_reg))
                       : open_mask;

    // Compare stage: one slot read per cycle; strict less keeps the lowest slot on ties.
    assign take = pipe_valid_reg && elig_mask[pipe_idx_reg]
               && (!best_found_reg || (rd_key < best_key_reg));

    assign ram_re    = (state_reg == S_SCAN) && (rd_ptr_reg < fill_count_reg);
    assign scan_done = (state_reg == S_SCAN) && (rd_ptr_reg == fill_count_reg)
                    && pipe_valid_reg;

    // Emit-cycle decisions.
    assign best_onehot    = MAX_SLOTS'(1) << best_idx_reg;
    assign new_below      = (new_key_reg < best_key_reg);
    assign frozen_upd     = new_below ? (frozen_reg | best_onehot) : (frozen_reg & ~best_onehot);
    assign any_open_after = |(valid_mask & ~frozen_upd);
    assign remaining      = |(elig_mask & ~best_onehot);
    assign more_frozen    = !phase_reg && (|frozen_mask);
    assign emit_run_last  = flush_mode_reg ? !remaining : !any_open_after;
    assign emit_flush_last = flush_mode_reg && !remaining && !more_frozen;

    // Write port: store a record during the fill, or write back into the emitted slot.
    // The scan of the next transaction starts only after this write, so no forwarding.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = fill_count_reg[IDX_W-1:0];
        ram_wdata = {record_key, record_payload};
        if (accept && (req_type == REQ_RECORD) && fill_room)
        begin
            ram_we = 1'b1;
        end
        else if ((state_reg == S_EMIT) && !flush_mode_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = best_idx_reg;
            ram_wdata = {new_key_reg, new_pay_reg};
        end
    end

    // Control and state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            fill_count_reg   <= '0;
            frozen_reg       <= '0;
            taken_reg        <= '0;
            cur_run_reg      <= '0;
            buf_size_reg     <= BUF_SIZE_RESET;
            flush_mode_reg   <= 1'b0;
            phase_reg        <= 1'b0;
            rd_ptr_reg       <= '0;
            pipe_valid_reg   <= 1'b0;
            best_found_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                buf_size_reg <= cfg_wdata;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (req_type == REQ_RECORD)
                        begin
                            if (fill_room)
                            begin
                                // Fill: store unfrozen, no result.
                                frozen_reg[fill_count_reg[IDX_W-1:0]] <= 1'b0;
                                fill_count_reg <= fill_count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                // Thaw everything if no slot is open.
                                if (!(|open_mask))
                                begin
                                    frozen_reg <= '0;
                                end
                                flush_mode_reg <= 1'b0;
                                rd_ptr_reg     <= '0;
                                pipe_valid_reg <= 1'b0;
                                best_found_reg <= 1'b0;
                                state_reg      <= S_SCAN;
                            end
                        end
                        else if (fill_count_reg != '0)
                        begin
                            // Flush: open group first, else straight to the frozen group.
                            flush_mode_reg <= 1'b1;
                            taken_reg      <= '0;
                            phase_reg      <= !(|open_mask);
                            rd_ptr_reg     <= '0;
                            pipe_valid_reg <= 1'b0;
                            best_found_reg <= 1'b0;
                            state_reg      <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    pipe_valid_reg <= ram_re;
                    if (ram_re)
                    begin
                        rd_ptr_reg <= rd_ptr_reg + CNT_W'(1);
                    end
                    if (take)
                    begin
                        best_found_reg <= 1'b1;
                    end
                    if (scan_done)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    result_valid_reg <= 1'b1;
                    if (emit_run_last && (cur_run_reg != '1))
                    begin
                        cur_run_reg <= cur_run_reg + RUN_W'(1);
                    end
                    if (!flush_mode_reg)
                    begin
                        frozen_reg <= any_open_after ? frozen_upd : '0;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        if (remaining || more_frozen)
                        begin
                            // Next pick: same group, or move to the frozen group.
                            taken_reg[best_idx_reg] <= 1'b1;
                            if (!remaining)
                            begin
                                phase_reg <= 1'b1;
                            end
                            rd_ptr_reg     <= '0;
                            pipe_valid_reg <= 1'b0;
                            best_found_reg <= 1'b0;
                            state_reg      <= S_SCAN;
                        end
                        else
                        begin
                            // Drained: empty and thaw the buffer, filling starts again.
                            frozen_reg     <= '0;
                            taken_reg      <= '0;
                            fill_count_reg <= '0;
                            flush_mode_reg <= 1'b0;
                            state_reg      <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath: best candidate, held record, result registers.
    always_ff @(posedge clk)
    begin
        pipe_idx_reg <= rd_ptr_reg[IDX_W-1:0];
        if (take)
        begin
            best_idx_reg <= pipe_idx_reg;
            best_key_reg <= rd_key;
            best_pay_reg <= rd_pay;
        end
        if (accept)
        begin
            new_key_reg <= record_key;
            new_pay_reg <= record_payload;
        end
        if (state_reg == S_EMIT)
        begin
            out_key_reg    <= best_key_reg;
            out_pay_reg    <= best_pay_reg;
            run_number_reg <= cur_run_reg;
            run_last_reg   <= emit_run_last;
            flush_last_reg <= emit_flush_last;
        end
    end

    assign result_valid = result_valid_reg;
    assign out_key      = out_key_reg;
    assign out_payload  = out_pay_reg;
    assign run_number   = run_number_reg;
    assign run_last     = run_last_reg;
    assign flush_last   = flush_last_reg;

    // Checks.
    `RSR_ASSERT_NEXT(a_no_result_from_idle, !busy, !result_valid,
        "result strobe without a selection in progress")
    `RSR_ASSERT_NOW(a_flush_last_closes_run, result_valid && flush_last, run_last,
        "final flush record does not close its run")
    `RSR_ASSERT_NOW(a_fill_in_range, 1'b1, fill_count_reg <= CNT_W'(MAX_SLOTS),
        "fill count beyond slot count")
    `RSR_ASSERT_NOW(a_scan_has_slots, state_reg == S_SCAN, fill_count_reg != '0,
        "scan started on an empty buffer")

endmodule

`default_nettype wire

@@ sv/rsr_ram.sv @@
`default_nettype none

module rsr_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
